/* design/gbn_pkg.sv */
// Shared types, constants and helpers for the go-back-N send window.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam int SEQ_W      = 32;
	localparam int HANDLE_W   = 16;
	localparam int LEN_W      = 16;
	localparam int PORT_W     = 8;
	localparam int TYPE_W     = 8;
	localparam int REQ_W      = 2;
	localparam int LIMIT_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = LIMIT_W'(4);
	localparam logic [TYPE_W-1:0]  ACK_MASK_RST    = TYPE_W'(1);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t FULL_CNT = cnt_t'(WINDOW_DEPTH);

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ = 2'd0,
		REQ_RX  = 2'd1,
		REQ_TMO = 2'd2
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RETRY_LIMIT = 1'b0,
		CFG_ACK_MASK    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK_CMP,
		ST_RESEND,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
		logic [PORT_W-1:0]   port;
	} slot_entry_t;

	typedef struct packed {
		logic [REQ_W-1:0]  code;
		slot_entry_t       entry;
		logic [TYPE_W-1:0] pkt_type;
	} req_t;

	typedef struct packed {
		logic        strobe;
		logic        tx_valid;
		slot_entry_t entry;
		logic        full_reject;
		logic        acked;
		logic        limit_hit;
		cnt_t        occupancy;
		logic        last;
	} result_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		if (p == ptr_t'(WINDOW_DEPTH - 1)) begin
			return '0;
		end
		return p + ptr_t'(1);
	endfunction

endpackage

/* design/gbn_slot_ram.sv */
// Slot memory of the send window: one write port, one registered read port.
// Depends on gbn_pkg for the slot entry type and pointer width.
`timescale 1ns / 1ps

module gbn_slot_ram (
	input  logic                clk,
	input  logic                we,
	input  gbn_pkg::ptr_t       waddr,
	input  gbn_pkg::slot_entry_t wdata,
	input  gbn_pkg::ptr_t       raddr,
	output gbn_pkg::slot_entry_t rdata
);
	import gbn_pkg::*;

	slot_entry_t mem [WINDOW_DEPTH];
	slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/gbn_ctrl.sv */
// Window sequencer: ring pointers, held count, retry counter, and the walk
// over the slot memory read port for ack checks and resends.
// Depends on gbn_pkg; drives gbn_slot_ram and builds at most one result per cycle.
`timescale 1ns / 1ps

module gbn_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  gbn_pkg::req_t           req,
	input  logic [gbn_pkg::LIMIT_W-1:0] retry_limit,
	input  logic [gbn_pkg::TYPE_W-1:0]  ack_mask,
	input  gbn_pkg::slot_entry_t    rdata,
	output logic                    we,
	output gbn_pkg::ptr_t           waddr,
	output gbn_pkg::slot_entry_t    wdata,
	output gbn_pkg::ptr_t           raddr,
	output logic                    busy,
	output gbn_pkg::result_t        res
);
	import gbn_pkg::*;

	state_t               state_q, state_d;
	ptr_t                 oldest_q, oldest_d;
	ptr_t                 next_free_q, next_free_d;
	cnt_t                 held_q, held_d;
	logic [LIMIT_W-1:0]   retry_q, retry_d;
	logic [SEQ_W-1:0]     seq_q, seq_d;
	logic                 hit_q, hit_d;
	ptr_t                 rd_ptr_q, rd_ptr_d;
	cnt_t                 remain_q, remain_d;
	logic                 rd_vld_s1, rd_vld_d;
	logic                 rd_last_s1, rd_last_d;
	logic [LIMIT_W:0]     retry_next;

	assign retry_next = {1'b0, retry_q} + (LIMIT_W+1)'(1);
	assign busy       = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			next_free_q <= '0;
			held_q      <= '0;
			retry_q     <= '0;
			hit_q       <= 1'b0;
			rd_ptr_q    <= '0;
			remain_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			oldest_q    <= oldest_d;
			next_free_q <= next_free_d;
			held_q      <= held_d;
			retry_q     <= retry_d;
			hit_q       <= hit_d;
			rd_ptr_q    <= rd_ptr_d;
			remain_q    <= remain_d;
			rd_vld_s1   <= rd_vld_d;
			rd_last_s1  <= rd_last_d;
		end
	end

	always_ff @(posedge clk) begin
		seq_q <= seq_d;
	end

	always_comb begin
		state_d     = state_q;
		oldest_d    = oldest_q;
		next_free_d = next_free_q;
		held_d      = held_q;
		retry_d     = retry_q;
		seq_d       = seq_q;
		hit_d       = hit_q;
		rd_ptr_d    = rd_ptr_q;
		remain_d    = remain_q;
		rd_vld_d    = 1'b0;
		rd_last_d   = 1'b0;
		we          = 1'b0;
		waddr       = next_free_q;
		wdata       = req.entry;
		raddr       = oldest_q;
		res         = '0;
		res.occupancy = held_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_code_t'(req.code))
						REQ_ENQ: begin
							res.strobe = 1'b1;
							res.last   = 1'b1;
							if (held_q == FULL_CNT) begin
								res.full_reject = 1'b1;
							end else begin
								we            = 1'b1;
								next_free_d   = ptr_inc(next_free_q);
								held_d        = held_q + cnt_t'(1);
								res.tx_valid  = 1'b1;
								res.entry     = req.entry;
								res.occupancy = held_q + cnt_t'(1);
							end
						end
						REQ_RX: begin
							if (held_q != '0 && (req.pkt_type & ack_mask) != '0) begin
								// oldest slot is read at this edge, compare next cycle
								seq_d   = req.entry.seq;
								state_d = ST_ACK_CMP;
							end else begin
								res.strobe = 1'b1;
								res.last   = 1'b1;
							end
						end
						REQ_TMO: begin
							if (held_q != '0) begin
								if (retry_next >= {1'b0, retry_limit}) begin
									hit_d   = 1'b1;
									retry_d = '0;
								end else begin
									hit_d   = 1'b0;
									retry_d = retry_next[LIMIT_W-1:0];
								end
								rd_ptr_d = oldest_q;
								remain_d = held_q;
								state_d  = ST_RESEND;
							end else begin
								res.strobe = 1'b1;
								res.last   = 1'b1;
							end
						end
						default: begin
							res.strobe = 1'b1;
							res.last   = 1'b1;
						end
					endcase
				end
			end
			ST_ACK_CMP: begin
				res.strobe = 1'b1;
				res.last   = 1'b1;
				if (rdata.seq == seq_q) begin
					res.acked     = 1'b1;
					res.occupancy = held_q - cnt_t'(1);
					oldest_d      = ptr_inc(oldest_q);
					held_d        = held_q - cnt_t'(1);
					// window drains: restart the retry count
					if (held_q == cnt_t'(1)) begin
						retry_d = '0;
					end
				end
				state_d = ST_IDLE;
			end
			ST_RESEND: begin
				raddr     = rd_ptr_q;
				rd_ptr_d  = ptr_inc(rd_ptr_q);
				remain_d  = remain_q - cnt_t'(1);
				rd_vld_d  = 1'b1;
				rd_last_d = (remain_q == cnt_t'(1));
				if (remain_q == cnt_t'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// emit one resend beat per slot read
		if (rd_vld_s1) begin
			res.strobe    = 1'b1;
			res.tx_valid  = 1'b1;
			res.entry     = rdata;
			res.last      = rd_last_s1;
			res.limit_hit = rd_last_s1 & hit_q;
			res.occupancy = held_q;
		end
	end

endmodule

/* design/go_back_n_send_window_top.sv */
// Top level of the go-back-N send window: configuration registers, result
// register and ports. Depends on gbn_pkg, gbn_ctrl and gbn_slot_ram.
`timescale 1ns / 1ps

// A request is taken at a clock edge with start high and busy low; each
// result beat is on the result ports for exactly one cycle, marked by
// result_valid, and cannot be held off by the receiver. Enqueue (stored or
// rejected), an ignored packet and a timeout on an empty window keep busy
// low, and the result beat shows in the next cycle. An ack that may match
// holds busy while the oldest slot is read from the single read port of the
// slot memory. A timeout with n entries held holds busy while it reads one
// slot per cycle, and gives n beats, one per slot read, the last carrying
// last and limit_hit.
module go_back_n_send_window_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [gbn_pkg::REQ_W-1:0]           req_type,
	input  logic [gbn_pkg::PORT_W-1:0]          port_id,
	input  logic [gbn_pkg::HANDLE_W-1:0]        buf_handle,
	input  logic [gbn_pkg::LEN_W-1:0]           pkt_len,
	input  logic [gbn_pkg::SEQ_W-1:0]           seq_num,
	input  logic [gbn_pkg::TYPE_W-1:0]          pkt_type,
	input  logic                                cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                result_valid,
	output logic                                tx_valid,
	output logic [gbn_pkg::PORT_W-1:0]          tx_port,
	output logic [gbn_pkg::HANDLE_W-1:0]        tx_handle,
	output logic [gbn_pkg::LEN_W-1:0]           tx_len,
	output logic [gbn_pkg::SEQ_W-1:0]           tx_seq,
	output logic                                full_reject,
	output logic                                acked,
	output logic                                limit_hit,
	output logic [gbn_pkg::CNT_W-1:0]           occupancy,
	output logic                                last
);
	import gbn_pkg::*;

	logic [LIMIT_W-1:0] retry_limit_q;
	logic [TYPE_W-1:0]  ack_mask_q;
	req_t               req;
	result_t            res;
	logic               res_strobe_q;
	result_t            res_q;
	logic               ram_we;
	ptr_t               ram_waddr;
	ptr_t               ram_raddr;
	slot_entry_t        ram_wdata;
	slot_entry_t        ram_rdata;

	assign req.code         = req_type;
	assign req.entry.seq    = seq_num;
	assign req.entry.handle = buf_handle;
	assign req.entry.len    = pkt_len;
	assign req.entry.port   = port_id;
	assign req.pkt_type     = pkt_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			ack_mask_q    <= ACK_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata[LIMIT_W-1:0];
				CFG_ACK_MASK:    ack_mask_q    <= cfg_wdata[TYPE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gbn_slot_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gbn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.retry_limit (retry_limit_q),
		.ack_mask    (ack_mask_q),
		.rdata       (ram_rdata),
		.we          (ram_we),
		.waddr       (ram_waddr),
		.wdata       (ram_wdata),
		.raddr       (ram_raddr),
		.busy        (busy),
		.res         (res)
	);

	// hold each result beat for exactly one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= res.strobe;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res;
	end

	assign result_valid = res_strobe_q;
	assign tx_valid     = res_q.tx_valid;
	assign tx_port      = res_q.entry.port;
	assign tx_handle    = res_q.entry.handle;
	assign tx_len       = res_q.entry.len;
	assign tx_seq       = res_q.entry.seq;
	assign full_reject  = res_q.full_reject;
	assign acked        = res_q.acked;
	assign limit_hit    = res_q.limit_hit;
	assign occupancy    = res_q.occupancy;
	assign last         = res_q.last;

endmodule
